// File: rtl/b64pcm_pkg.sv
// Package with the shared types, codes, constants and symbol decode of the base64 to PCM unit.
`timescale 1ns / 1ps

package b64pcm_pkg;

  localparam int unsigned BATCH_SIZE = 512;
  localparam int unsigned CNT_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned ACC_W = 14;
  localparam int unsigned HELD_W = 4;

  localparam logic [1:0] OP_CONT  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EOS   = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               batch_end;
    logic [FILL_W-1:0]  batch_fill;
    logic [TOTAL_W-1:0] total_samples;
    logic               odd_dropped;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic       pad;
    logic [5:0] value;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s = '{valid: 1'b0, pad: 1'b0, value: 6'd0};
    if (c >= "A" && c <= "Z") begin
      s.valid = 1'b1;
      s.value = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      s.valid = 1'b1;
      s.value = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      s.valid = 1'b1;
      s.value = 6'(c - "0" + 8'd52);
    end else if (c == "+") begin
      s.valid = 1'b1;
      s.value = 6'd62;
    end else if (c == "/") begin
      s.valid = 1'b1;
      s.value = 6'd63;
    end else if (c == "=") begin
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

// File: rtl/b64pcm_dec.sv
// Decode state of the base64 to PCM unit: bit accumulator, byte pairing and stream counters.
`timescale 1ns / 1ps

module b64pcm_dec
  import b64pcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  input  item_t item,
  input  logic  advance,
  output logic  has_res,
  output res_t  res
);

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [HELD_W-1:0]  bits_r, bits_nxt;
  logic               closed_r, closed_nxt;
  logic [7:0]         low_r, low_nxt;
  logic               low_valid_r, low_valid_nxt;
  logic [CNT_W-1:0]   batch_r, batch_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  sym_t             sym;
  logic [ACC_W-1:0] acc_sh;
  logic [HELD_W-1:0] bits_sum;
  logic [7:0]       byte_out;

  always_comb begin
    acc_nxt       = acc_r;
    bits_nxt      = bits_r;
    closed_nxt    = closed_r;
    low_nxt       = low_r;
    low_valid_nxt = low_valid_r;
    batch_nxt     = batch_r;
    total_nxt     = total_r;
    has_res       = 1'b0;
    res           = '0;
    sym           = sym_decode(item.symbol);
    acc_sh        = '0;
    bits_sum      = '0;
    byte_out      = '0;

    if (item_valid) begin
      if (item.opcode == OP_EOS) begin
        has_res           = 1'b1;
        res.kind          = KIND_REPORT;
        res.batch_end     = (batch_r != '0);
        res.batch_fill    = FILL_W'(batch_r);
        res.total_samples = total_r;
        res.odd_dropped   = low_valid_r;
        acc_nxt           = '0;
        bits_nxt          = '0;
        closed_nxt        = 1'b0;
        low_nxt           = '0;
        low_valid_nxt     = 1'b0;
        batch_nxt         = '0;
        total_nxt         = '0;
      end else if (item.opcode == OP_CONT || item.opcode == OP_START) begin
        if (item.opcode == OP_START) begin
          acc_nxt    = '0;
          bits_nxt   = '0;
          closed_nxt = 1'b0;
        end
        if (!closed_nxt) begin
          if (sym.pad) begin
            closed_nxt = 1'b1;
          end else if (sym.valid) begin
            acc_sh   = {acc_nxt[ACC_W-7:0], sym.value};
            bits_sum = bits_nxt + HELD_W'(6);
            acc_nxt  = acc_sh;
            bits_nxt = bits_sum;
            if (bits_sum >= HELD_W'(8)) begin
              bits_nxt = bits_sum - HELD_W'(8);
              byte_out = 8'(acc_sh >> bits_nxt);
              acc_nxt  = acc_sh & ACC_W'((15'd1 << bits_nxt) - 15'd1);
              if (!low_valid_r) begin
                low_nxt       = byte_out;
                low_valid_nxt = 1'b1;
              end else begin
                has_res       = 1'b1;
                res.kind      = KIND_SAMPLE;
                res.sample    = {byte_out, low_r};
                low_nxt       = '0;
                low_valid_nxt = 1'b0;
                if (total_r != '1) begin
                  total_nxt = total_r + TOTAL_W'(1);
                end
                if (batch_r == CNT_W'(BATCH_SIZE - 1)) begin
                  batch_nxt     = '0;
                  res.batch_end = 1'b1;
                end else begin
                  batch_nxt = batch_r + CNT_W'(1);
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      bits_r      <= '0;
      closed_r    <= 1'b0;
      low_r       <= '0;
      low_valid_r <= 1'b0;
      batch_r     <= '0;
      total_r     <= '0;
    end else if (advance) begin
      acc_r       <= acc_nxt;
      bits_r      <= bits_nxt;
      closed_r    <= closed_nxt;
      low_r       <= low_nxt;
      low_valid_r <= low_valid_nxt;
      batch_r     <= batch_nxt;
      total_r     <= total_nxt;
    end
  end

endmodule

// File: rtl/base64_to_pcm16_sample_stream_unit.sv
// Top level of the base64 character stream to signed 16-bit PCM sample unit.
`timescale 1ns / 1ps

// The input channel carries one word per character: an opcode (continue run, start run,
// end of stream) and the raw character byte. The output channel carries at most one word
// per input word: a decoded sample, or the end-of-stream report with batch fill, the
// saturating sample total and the odd-byte flag.
// An accepted word is held in an input register and is then decoded into the output
// register, from which its result is presented on the output. One word is accepted
// every cycle while in_stall is low; the decode of a word and the state it updates
// lie combinationally between the input and output registers.
// Words that produce no result leave the input register even while the output stalls.
// When the receiver stalls, the finished result waits in the output register, and the
// input register still drains words that give no result; a word with a result waits
// there and then in_stall rises until the output register frees up.
// A synchronous reset empties both registers and clears all decode state, sample
// and batch counters.

module base64_to_pcm16_sample_stream_unit
  import b64pcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [15:0] out_sample,
  output logic               out_batch_end,
  output logic [FILL_W-1:0]  out_batch_fill,
  output logic [TOTAL_W-1:0] out_total_samples,
  output logic               out_odd_dropped
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;
  logic  has_res;
  res_t  res;
  logic  advance;
  logic  in_accept;
  logic  out_load;

  b64pcm_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .advance    (advance),
    .has_res    (has_res),
    .res        (res)
  );

  assign advance   = s1_valid_r && (!has_res || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = advance && has_res;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{opcode: in_opcode, symbol: in_symbol};
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_sample        = out_res_r.sample;
  assign out_batch_end     = out_res_r.batch_end;
  assign out_batch_fill    = out_res_r.batch_fill;
  assign out_total_samples = out_res_r.total_samples;
  assign out_odd_dropped   = out_res_r.odd_dropped;

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("Input word lost while waiting for the output register.");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && has_res && out_valid_r))
    else $error("Input stalled without a blocked result.");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_REPORT) |-> (out_sample == 16'sd0))
    else $error("Report word carries a nonzero sample.");

  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_SAMPLE) |->
      (out_batch_fill == '0 && out_total_samples == '0 && !out_odd_dropped))
    else $error("Sample word carries report fields.");

endmodule
